### rtl/bf_dec_pkg.sv
// shared types and constants for the blowfish block decryptor
// no dependencies

package bf_dec_pkg;

	localparam int unsigned SUBKEY_COUNT = 18;
	localparam int unsigned SUBKEY_AW    = $clog2(SUBKEY_COUNT);
	localparam int unsigned SBOX_COUNT   = 4;
	localparam int unsigned SBOX_DEPTH   = 256;
	localparam int unsigned SBOX_AW      = $clog2(SBOX_DEPTH);
	localparam int unsigned ROUNDS       = 16;
	localparam int unsigned ROUND_W      = $clog2(ROUNDS);

	localparam logic [SUBKEY_AW-1:0] KEY_R_IDX     = SUBKEY_AW'(17);
	localparam logic [SUBKEY_AW-1:0] KEY_L_IDX     = SUBKEY_AW'(16);
	localparam logic [SUBKEY_AW-1:0] KEY_FIRST_IDX = SUBKEY_AW'(15);
	localparam logic [ROUND_W-1:0]   ROUND_LAST    = ROUND_W'(ROUNDS - 1);

	typedef enum logic [1:0] {
		OP_KEY_WR  = 2'd0,
		OP_SBOX_WR = 2'd1,
		OP_DECRYPT = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KEY_L,
		ST_KEY_R,
		ST_ROUND,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [9:0]  table_index;
		logic [31:0] table_word;
		logic [63:0] cipher_block;
		logic        last_block;
	} in_item_t;

	typedef struct packed {
		logic [63:0] plain_block;
		logic        last_block_out;
	} out_item_t;

endpackage

### rtl/blowfish_block_decrypt_top.sv
// blowfish ecb block decryptor with loadable subkey and s-box stores
// depends on bf_dec_pkg
// a decrypt item reads the outer subkeys in ST_KEY_L and ST_KEY_R, then runs one
//   feistel round per cycle through the four s-box banks in ST_ROUND; ST_DONE loads
//   the result once the output is free, and no new command is taken before that
// key and s-box word writes are taken one per cycle while no decrypt is running
// reset clears the sequencer and result valid; key stores are undefined until written

module blowfish_block_decrypt_top
	import bf_dec_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  in_item_t  cmd,
	output logic      res_valid,
	input  logic      res_ready,
	output out_item_t res
);

	state_t state_q, state_d;
	logic [ROUND_W-1:0] rnd_q, rnd_d;

	logic [31:0] key_mem [SUBKEY_COUNT];
	logic [31:0] sbox_mem [SBOX_COUNT][SBOX_DEPTH];

	logic [SUBKEY_AW-1:0] key_ra;
	logic [31:0]          key_rd_q;
	logic                 key_we;
	logic [SBOX_AW-1:0]   sbox_ra [SBOX_COUNT];
	logic [31:0]          sbox_rd_q [SBOX_COUNT];
	logic                 sbox_we;

	logic [63:0] blk_q;
	logic        last_q;
	logic [31:0] x_q, y_q;
	logic [31:0] f_val, y_new, x_new, x_init, ra_word;

	logic      cmd_acc, res_load;
	out_item_t res_q;
	logic      res_valid_q;

	assign cmd_acc = cmd_valid && cmd_ready;
	assign key_we  = cmd_acc && (cmd.operation == OP_KEY_WR) && (cmd.table_index[9:SUBKEY_AW] == '0)
		&& (cmd.table_index[SUBKEY_AW-1:0] < SUBKEY_AW'(SUBKEY_COUNT));
	assign sbox_we = cmd_acc && (cmd.operation == OP_SBOX_WR);

	// round function
	assign f_val  = ((sbox_rd_q[0] + sbox_rd_q[1]) ^ sbox_rd_q[2]) + sbox_rd_q[3];
	assign y_new  = y_q ^ f_val;
	assign x_new  = x_q ^ key_rd_q;
	assign x_init = blk_q[31:0] ^ key_rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q   <= '0;
		end else begin
			state_q <= state_d;
			rnd_q   <= rnd_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		rnd_d     = rnd_q;
		cmd_ready = 1'b0;
		res_load  = 1'b0;
		key_ra    = KEY_L_IDX;
		ra_word   = x_init;
		unique case (state_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid && (cmd.operation == OP_DECRYPT)) begin
					state_d = ST_KEY_L;
				end
			end
			ST_KEY_L: begin
				key_ra  = KEY_R_IDX;
				state_d = ST_KEY_R;
			end
			ST_KEY_R: begin
				key_ra  = KEY_FIRST_IDX;
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				ra_word = y_new;
				rnd_d   = rnd_q + 1'b1;
				if (rnd_q == ROUND_LAST) begin
					key_ra  = '0;
					state_d = ST_DONE;
				end else begin
					key_ra = KEY_FIRST_IDX - SUBKEY_AW'(1) - SUBKEY_AW'(rnd_q);
				end
			end
			ST_DONE: begin
				if (!res_valid_q || res_ready) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		for (int b = 0; b < SBOX_COUNT; b++) begin
			sbox_ra[b] = ra_word[(SBOX_COUNT-1-b)*8 +: SBOX_AW];
		end
	end

	// subkey store
	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[cmd.table_index[SUBKEY_AW-1:0]] <= cmd.table_word;
		end
		key_rd_q <= key_mem[key_ra];
	end

	// s-box store, one bank per box
	always_ff @(posedge clk) begin
		for (int b = 0; b < SBOX_COUNT; b++) begin
			if (sbox_we && (cmd.table_index[9:SBOX_AW] == 2'(b))) begin
				sbox_mem[b][cmd.table_index[SBOX_AW-1:0]] <= cmd.table_word;
			end
			sbox_rd_q[b] <= sbox_mem[b][sbox_ra[b]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc && (cmd.operation == OP_DECRYPT)) begin
			blk_q  <= cmd.cipher_block;
			last_q <= cmd.last_block;
		end
		unique case (state_q)
			ST_KEY_L: y_q <= blk_q[63:32] ^ key_rd_q;
			ST_KEY_R: x_q <= x_init;
			ST_ROUND: begin
				x_q <= y_new;
				y_q <= x_new;
			end
			default: begin
			end
		endcase
		if (res_load) begin
			res_q.plain_block    <= {x_q, y_q};
			res_q.last_block_out <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_rnd_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_ROUND) |-> (rnd_q == '0))
		else $error("round counter not cleared outside rounds");

	a_decrypt_start: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_acc && (cmd.operation == OP_DECRYPT)) |=> (state_q == ST_KEY_L))
		else $error("decrypt item did not start key fetch");

	a_rounds_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && rnd_q == ROUND_LAST) |=> (state_q == ST_DONE))
		else $error("last round did not finish");

	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> (res_valid_q && (state_q == ST_IDLE)))
		else $error("result not presented after load");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_ready) |-> !res_load)
		else $error("pending result overwritten");

endmodule

### bench/blowfish_block_decrypt_top_tb.sv
// testbench for blowfish_block_decrypt_top: loads a full key, then decrypts blocks
// and compares each result against an in-bench blowfish decryption predictor
// depends on bf_dec_pkg and blowfish_block_decrypt_top
`timescale 1ns / 1ps

module blowfish_block_decrypt_top_tb;
	import bf_dec_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_ready;
	in_item_t  cmd;
	logic      res_valid;
	logic      res_ready;
	out_item_t res;

	logic [31:0] subkey_mem [0:SUBKEY_COUNT-1];
	logic [31:0] sbox_mem [0:SBOX_COUNT*SBOX_DEPTH-1];
	out_item_t   plain_q [$];
	int          mismatch_count;
	bit          send_idle;
	bit          recv_idle;

	blowfish_block_decrypt_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [31:0] round_f(logic [31:0] x);
		return ((sbox_mem[{2'd0, x[31:24]}] + sbox_mem[{2'd1, x[23:16]}])
			^ sbox_mem[{2'd2, x[15:8]}]) + sbox_mem[{2'd3, x[7:0]}];
	endfunction

	function automatic logic [63:0] blowfish_decipher(logic [63:0] blk);
		logic [31:0] lw;
		logic [31:0] rw;
		lw = blk[63:32] ^ subkey_mem[KEY_L_IDX];
		rw = blk[31:0] ^ subkey_mem[KEY_R_IDX];
		for (int k = KEY_FIRST_IDX; k >= 1; k -= 2) begin
			lw ^= round_f(rw);
			rw ^= subkey_mem[k];
			rw ^= round_f(lw);
			lw ^= subkey_mem[k-1];
		end
		return {rw, lw};
	endfunction

	function automatic in_item_t make_item(op_t op, logic [9:0] idx, logic [31:0] word,
			logic [63:0] blk, logic last);
		in_item_t it;
		it.operation    = op;
		it.table_index  = idx;
		it.table_word   = word;
		it.cipher_block = blk;
		it.last_block   = last;
		return it;
	endfunction

	// key and s-box writes update the predictor, decrypts queue a plaintext
	task automatic apply_cmd(input in_item_t c);
		out_item_t want;
		case (c.operation)
			OP_KEY_WR: begin
				if (c.table_index < SUBKEY_COUNT)
					subkey_mem[c.table_index] = c.table_word;
			end
			OP_SBOX_WR: begin
				sbox_mem[c.table_index] = c.table_word;
			end
			OP_DECRYPT: begin
				want.plain_block    = blowfish_decipher(c.cipher_block);
				want.last_block_out = c.last_block;
				plain_q.push_back(want);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (cmd_valid && cmd_ready)
				apply_cmd(cmd);
			if (res_valid && res_ready) begin
				if (plain_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected item: plain %h last %b",
							res.plain_block, res.last_block_out);
				end else begin
					want = plain_q.pop_front();
					if (res.plain_block !== want.plain_block ||
						res.last_block_out !== want.last_block_out) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("bad item: plain %h last %b, expected plain %h last %b",
								res.plain_block, res.last_block_out,
								want.plain_block, want.last_block_out);
					end
				end
			end
		end
	end

	initial begin
		int stall;
		res_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = recv_idle ? $urandom_range(0, 13) : 0;
			if (stall > 0) begin
				@(negedge clk);
				res_ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			res_ready <= 1'b1;
			do @(posedge clk); while (!res_valid);
		end
	end

	task automatic send_cmd(input in_item_t it);
		int gap;
		gap = send_idle ? $urandom_range(0, 13) : 0;
		@(negedge clk);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= it;
		do @(posedge clk); while (!cmd_ready);
	endtask

	task automatic drain_results();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (plain_q.size() != 0) @(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	task automatic send_decrypt(input logic [63:0] blk, input logic last);
		send_cmd(make_item(OP_DECRYPT, 10'($urandom), $urandom, blk, last));
	endtask

	task automatic send_write(input op_t op, input logic [9:0] idx, input logic [31:0] word);
		send_cmd(make_item(op, idx, word, rand64(), 1'($urandom)));
	endtask

	task automatic test_key_load();
		for (int i = 0; i < SUBKEY_COUNT; i++)
			send_write(OP_KEY_WR, 10'(i), $urandom);
		for (int i = 0; i < SBOX_COUNT*SBOX_DEPTH; i++)
			send_write(OP_SBOX_WR, 10'(i), $urandom);
	endtask

	task automatic test_edges();
		send_decrypt(64'h0, 1'b0);
		send_decrypt('1, 1'b1);
		send_decrypt(64'h8000_0000_0000_0001, 1'b0);
		send_decrypt(64'h0123_4567_89ab_cdef, 1'b1);
		send_write(OP_SBOX_WR, 10'd0, 32'h0);
		send_write(OP_SBOX_WR, 10'd1023, 32'hffff_ffff);
		send_write(OP_KEY_WR, 10'd0, 32'hffff_ffff);
		send_write(OP_KEY_WR, 10'(KEY_R_IDX), 32'h0);
		send_decrypt(64'h0, 1'b1);
		send_decrypt('1, 1'b0);
		// subkey writes past the array and the unused code change nothing
		send_write(OP_KEY_WR, 10'd18, $urandom);
		send_write(OP_KEY_WR, 10'd1023, $urandom);
		send_write(OP_NONE, 10'($urandom), $urandom);
		send_write(OP_NONE, '1, 32'hffff_ffff);
		send_cmd(make_item(OP_DECRYPT, '1, 32'hffff_ffff, rand64(), 1'b1));
		send_cmd(make_item(OP_DECRYPT, '0, 32'h0, rand64(), 1'b0));
	endtask

	task automatic test_pause_drain();
		for (int i = 0; i < 4; i++)
			send_decrypt(rand64(), i == 3);
		drain_results();
		send_write(OP_KEY_WR, 10'($urandom_range(0, SUBKEY_COUNT - 1)), $urandom);
		send_decrypt(rand64(), 1'b1);
		drain_results();
	endtask

	task automatic test_random_traffic();
		int sent;
		int kind;
		int len;
		sent = 0;
		while (sent < 290) begin
			if ($urandom_range(0, 5) == 0)
				send_idle = !send_idle;
			if ($urandom_range(0, 5) == 0)
				recv_idle = !recv_idle;
			kind = $urandom_range(0, 9);
			if (kind <= 5) begin
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++)
					send_decrypt(rand64(), (i == len - 1) ? 1'b1 : 1'($urandom_range(0, 7) == 0));
				sent += len;
			end else if (kind <= 7) begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++)
					send_write(OP_SBOX_WR, 10'($urandom), $urandom);
				sent += len;
			end else if (kind == 8) begin
				len = $urandom_range(1, 3);
				for (int i = 0; i < len; i++)
					send_write(OP_KEY_WR, 10'($urandom_range(0, SUBKEY_COUNT - 1)), $urandom);
				sent += len;
			end else if ($urandom_range(0, 1) == 0) begin
				send_write(OP_KEY_WR, 10'($urandom_range(SUBKEY_COUNT, 1023)), $urandom);
				sent += 1;
			end else begin
				send_write(OP_NONE, 10'($urandom), $urandom);
				sent += 1;
			end
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		cmd_valid      = 1'b0;
		cmd            = '0;
		mismatch_count = 0;
		send_idle      = 1'b1;
		recv_idle      = 1'b1;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		test_key_load();
		test_edges();
		test_pause_drain();
		test_random_traffic();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (plain_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && plain_q.size() == 0)
			$display("blowfish_block_decrypt_top: match");
		else
			$display("blowfish_block_decrypt_top: mismatch");
		$finish;
	end

	initial begin
		#2500000;
		$display("blowfish_block_decrypt_top: mismatch");
		$finish;
	end

endmodule

### files.f
rtl/bf_dec_pkg.sv
rtl/blowfish_block_decrypt_top.sv
bench/blowfish_block_decrypt_top_tb.sv
